// ----- rtl/assert_macros.svh -----
// Assertion macros shared by the timer table RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Check that an antecedent implies a consequent in the same cycle
`define ASSERT_IMPL(lbl, clk, rst_n, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("assertion failed");
// Check that an antecedent implies a consequent in the next cycle
`define ASSERT_NEXT(lbl, clk, rst_n, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("assertion failed");
`endif

// ----- rtl/itt_pkg.sv -----
// Package for the interval timer table: commands, states, control structs
package itt_pkg;
    localparam int TimersDef = 16;
    localparam int MaskW     = 16;
    localparam logic [63:0] AllOnes = '1;

    typedef enum logic [2:0] {
        CMD_ARM  = 3'd0,
        CMD_GET  = 3'd1,
        CMD_READ = 3'd2,
        CMD_POLL = 3'd3,
        CMD_TICK = 3'd4
    } t_cmd;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RD,
        ST_ACC,
        ST_SCAN_RD,
        ST_SCAN_CHK,
        ST_DIV,
        ST_SCAN_WR,
        ST_DONE,
        ST_OUT
    } t_state;

    // Controller to datapath
    typedef struct packed {
        logic load_in;
        logic rd_slot;
        logic do_access;
        logic clr_scan;
        logic rd_scan;
        logic div_start;
        logic wr_scan;
        logic inc_scan;
        logic clr_res;
    } t_ctl;

    // Datapath to controller
    typedef struct packed {
        logic is_tick;
        logic valid_acc;
        logic scan_fire;
        logic scan_per;
        logic scan_last;
        logic div_done;
    } t_sts;
endpackage

// ----- rtl/itt_divider.sv -----
// Radix-2 restoring divider, 64-bit quotient and remainder, one bit per cycle
module itt_divider import itt_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [63:0] i_num,
    input  logic [63:0] i_den,
    output logic        o_done,
    output logic [63:0] o_quo,
    output logic [63:0] o_rem
);
    logic [63:0] r_quo, n_quo;
    logic [63:0] r_rem, n_rem;
    logic [63:0] r_den;
    logic [6:0]  r_cnt, n_cnt;
    logic        r_busy, n_busy;
    logic        r_done, n_done;
    logic [64:0] w_sh;

    // Shift in one numerator bit and try a subtract
    always_comb begin
        n_quo  = r_quo;
        n_rem  = r_rem;
        n_cnt  = r_cnt;
        n_busy = r_busy;
        n_done = 1'b0;
        w_sh   = {r_rem, r_quo[63]};
        if (i_start) begin
            n_quo  = i_num;
            n_rem  = '0;
            n_cnt  = 7'd0;
            n_busy = 1'b1;
        end else if (r_busy) begin
            if (w_sh >= {1'b0, r_den}) begin
                n_rem = 64'(w_sh - {1'b0, r_den});
                n_quo = {r_quo[62:0], 1'b1};
            end else begin
                n_rem = w_sh[63:0];
                n_quo = {r_quo[62:0], 1'b0};
            end
            n_cnt = r_cnt + 7'd1;
            if (r_cnt == 7'd63) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_quo <= n_quo;
        r_rem <= n_rem;
        if (i_start) r_den <= i_den;
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;
    assign o_rem  = r_rem;
endmodule

// ----- rtl/itt_datapath.sv -----
// Datapath: timer table registers, access logic, tick scan and result registers
module itt_datapath import itt_pkg::*; #(
    parameter int TIMERS = TimersDef
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_ctl        i_ctl,
    output t_sts        o_sts,
    input  logic [2:0]  i_cmd,
    input  logic [3:0]  i_slot,
    input  logic [63:0] i_now_ns,
    input  logic [63:0] i_value_ns,
    input  logic [63:0] i_period_ns,
    input  logic        i_absolute,
    output logic        o_status,
    output logic [63:0] o_count,
    output logic [63:0] o_remaining_ns,
    output logic [63:0] o_old_period_ns,
    output logic [MaskW-1:0] o_fired_mask,
    output logic        o_readable
);
    localparam int IW = (TIMERS > 1) ? $clog2(TIMERS) : 1;

    logic [63:0] r_exp [TIMERS];
    logic [63:0] r_per [TIMERS];
    logic [63:0] r_pend [TIMERS];
    logic [TIMERS-1:0] r_armed;

    // latched item
    logic [2:0]  r_cmd;
    logic [3:0]  r_slot;
    logic [63:0] r_now, r_val, r_pin;
    logic        r_abs;

    // slot / scan read registers
    logic [IW-1:0] r_idx;
    logic [63:0] r_e, r_p, r_c;
    logic        r_a;
    logic [63:0] r_past;
    logic        r_fire;

    // results
    logic        r_status, r_readable;
    logic [63:0] r_count, r_rem, r_oper;
    logic [MaskW-1:0] r_mask;

    logic        w_in_table;
    logic [IW-1:0] w_sidx;
    logic [63:0] w_left, w_sum, w_newexp, w_base, w_bsum, w_q1, w_pend;
    logic        w_div_done;
    logic [63:0] w_quo, w_drem;

    assign w_in_table = ({1'b0, r_slot} < 5'(TIMERS > 16 ? 16 : TIMERS));
    assign w_sidx = IW'(r_slot);

    itt_divider u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(i_ctl.div_start),
        .i_num(r_past), .i_den(r_p), .o_done(w_div_done),
        .o_quo(w_quo), .o_rem(w_drem)
    );

    // Access arithmetic on the registered slot entry
    always_comb begin
        w_left   = (r_a && r_e > r_now) ? 64'(r_e - r_now) : '0;
        w_sum    = 64'(r_now + r_val);
        w_newexp = r_abs ? r_val : ((w_sum < r_now) ? AllOnes : w_sum);
        w_base   = 64'(r_now - w_drem);
        w_bsum   = 64'(w_base + r_p);
        w_q1     = (w_quo == AllOnes) ? AllOnes : 64'(w_quo + 64'd1);
        w_pend   = 64'(r_c + (r_p != 0 ? w_q1 : 64'd1));
        if (w_pend < r_c) w_pend = AllOnes;
    end

    assign o_sts.is_tick   = (r_cmd == CMD_TICK);
    assign o_sts.valid_acc = w_in_table;
    assign o_sts.scan_fire = r_fire;
    assign o_sts.scan_per  = (r_p != 0);
    assign o_sts.scan_last = ({1'b0, r_idx} == (IW+1)'(TIMERS - 1));
    assign o_sts.div_done  = w_div_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_armed <= '0;
            for (int k = 0; k < TIMERS; k++) begin
                r_exp[k]  <= '0;
                r_per[k]  <= '0;
                r_pend[k] <= '0;
            end
        end else begin
            // Access a single slot
            if (i_ctl.do_access) begin
                unique case (r_cmd)
                    CMD_ARM: begin
                        r_rem  <= w_left;
                        r_oper <= r_p;
                        if (r_val == 0) begin
                            r_armed[w_sidx] <= 1'b0;
                            r_exp[w_sidx]   <= '0;
                            r_per[w_sidx]   <= '0;
                        end else begin
                            r_armed[w_sidx] <= 1'b1;
                            r_exp[w_sidx]   <= w_newexp;
                            r_per[w_sidx]   <= r_pin;
                        end
                    end
                    CMD_GET: begin
                        r_rem  <= w_left;
                        r_oper <= r_p;
                    end
                    CMD_READ: begin
                        r_count  <= r_c;
                        r_status <= (r_c == 0);
                        r_pend[w_sidx] <= '0;
                    end
                    CMD_POLL: r_readable <= (r_c != 0);
                    default: ;
                endcase
            end
            // Commit a fired timer
            if (i_ctl.wr_scan) begin
                r_pend[r_idx] <= w_pend;
                if (r_p != 0) begin
                    r_exp[r_idx] <= (w_bsum < w_base) ? AllOnes : w_bsum;
                end else begin
                    r_armed[r_idx] <= 1'b0;
                end
                if ({1'b0, r_idx} < (IW+1)'(MaskW)) r_mask[4'(r_idx)] <= 1'b1;
            end
        end
        // Latch the input beat
        if (i_ctl.load_in) begin
            r_cmd  <= i_cmd;
            r_slot <= i_slot;
            r_now  <= i_now_ns;
            r_val  <= i_value_ns;
            r_pin  <= i_period_ns;
            r_abs  <= i_absolute;
        end
        if (i_ctl.clr_res) begin
            r_status <= 1'b0; r_readable <= 1'b0; r_count <= '0;
            r_rem <= '0; r_oper <= '0; r_mask <= '0;
        end
        // Fetch one entry
        if (i_ctl.rd_slot || i_ctl.rd_scan) begin
            r_e <= r_exp[i_ctl.rd_slot ? w_sidx : r_idx];
            r_p <= r_per[i_ctl.rd_slot ? w_sidx : r_idx];
            r_c <= r_pend[i_ctl.rd_slot ? w_sidx : r_idx];
            r_a <= r_armed[i_ctl.rd_slot ? w_sidx : r_idx];
        end
        // Decide expiry of the scanned entry along with the fetch
        if (i_ctl.rd_scan) begin
            r_fire <= r_armed[r_idx] && (r_exp[r_idx] <= r_now);
            r_past <= 64'(r_now - r_exp[r_idx]);
        end
        if (i_ctl.clr_scan) r_idx <= '0;
        else if (i_ctl.inc_scan) r_idx <= IW'(r_idx + 1'b1);
    end

    assign o_status        = r_status;
    assign o_count         = r_count;
    assign o_remaining_ns  = r_rem;
    assign o_old_period_ns = r_oper;
    assign o_fired_mask    = r_mask;
    assign o_readable      = r_readable;
endmodule

// ----- rtl/itt_ctrl.sv -----
// Controller: sequences slot access and the timer scan of a tick
module itt_ctrl import itt_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_ready,
    output logic o_valid,
    input  logic i_ready,
    input  t_sts i_sts,
    output t_ctl o_ctl
);
    t_state r_st, n_st;

    // Next state
    always_comb begin
        n_st = r_st;
        unique case (r_st)
            ST_IDLE:     if (i_valid) n_st = ST_RD;
            ST_RD:       n_st = i_sts.is_tick ? ST_SCAN_RD : ST_ACC;
            ST_ACC:      n_st = ST_OUT;
            ST_SCAN_RD:  n_st = ST_SCAN_CHK;
            ST_SCAN_CHK: begin
                if (!i_sts.scan_fire) n_st = ST_DONE;
                else if (i_sts.scan_per) n_st = ST_DIV;
                else n_st = ST_SCAN_WR;
            end
            ST_DIV:      if (i_sts.div_done) n_st = ST_SCAN_WR;
            ST_SCAN_WR:  n_st = ST_DONE;
            ST_DONE:     n_st = i_sts.scan_last ? ST_OUT : ST_SCAN_RD;
            ST_OUT:      if (i_ready) n_st = ST_IDLE;
            default:     n_st = ST_IDLE;
        endcase
    end

    // Outputs
    always_comb begin
        o_ctl   = '0;
        o_ready = 1'b0;
        o_valid = 1'b0;
        unique case (r_st)
            ST_IDLE: begin
                o_ready       = 1'b1;
                o_ctl.load_in = i_valid;
            end
            ST_RD: begin
                o_ctl.rd_slot  = 1'b1;
                o_ctl.clr_scan = 1'b1;
                o_ctl.clr_res  = 1'b1;
            end
            ST_ACC:      o_ctl.do_access = i_sts.valid_acc;
            ST_SCAN_RD:  o_ctl.rd_scan = 1'b1;
            ST_SCAN_CHK: o_ctl.div_start = 1'b0;
            ST_DIV:      o_ctl.div_start = 1'b0;
            ST_SCAN_WR:  o_ctl.wr_scan = 1'b1;
            ST_DONE:     o_ctl.inc_scan = 1'b1;
            ST_OUT:      o_valid = 1'b1;
            default: ;
        endcase
        // Launch the divide on entry to the divide state
        if (r_st == ST_SCAN_CHK && n_st == ST_DIV) o_ctl.div_start = 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_st <= ST_IDLE;
        else r_st <= n_st;
    end
endmodule

// ----- rtl/interval_timer_table.sv -----
// Interval timer table: one access or tick beat in, one result beat out.
// Slot access (arm, get, read, poll): result beat after the slot read and access states,
// next input beat accepted in the cycle after the result beat is taken.
// Tick: a read state, then a scan of TIMERS entries (read, check and done per timer,
// plus a write per fired timer and a divide per fired periodic one); one item in flight.
// Reset (synchronous, active low) disarms all timers and clears all counts.
`include "assert_macros.svh"
module interval_timer_table import itt_pkg::*; #(
    parameter int TIMERS = TimersDef
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [2:0]  i_cmd,
    input  logic [3:0]  i_slot,
    input  logic [63:0] i_now_ns,
    input  logic [63:0] i_value_ns,
    input  logic [63:0] i_period_ns,
    input  logic        i_absolute,
    output logic        o_valid,
    input  logic        i_ready,
    output logic        o_status,
    output logic [63:0] o_count,
    output logic [63:0] o_remaining_ns,
    output logic [63:0] o_old_period_ns,
    output logic [15:0] o_fired_mask,
    output logic        o_readable
);
    t_ctl w_ctl;
    t_sts w_sts;

    itt_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_ready(o_ready),
        .o_valid(o_valid), .i_ready(i_ready), .i_sts(w_sts), .o_ctl(w_ctl)
    );

    itt_datapath #(.TIMERS(TIMERS)) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_ctl(w_ctl), .o_sts(w_sts),
        .i_cmd(i_cmd), .i_slot(i_slot), .i_now_ns(i_now_ns),
        .i_value_ns(i_value_ns), .i_period_ns(i_period_ns),
        .i_absolute(i_absolute), .o_status(o_status), .o_count(o_count),
        .o_remaining_ns(o_remaining_ns), .o_old_period_ns(o_old_period_ns),
        .o_fired_mask(o_fired_mask), .o_readable(o_readable)
    );

    `ASSERT_IMPL(a_no_overlap, i_clk, i_rst_n, o_valid, !o_ready)
    `ASSERT_NEXT(a_accept_busy, i_clk, i_rst_n, i_valid && o_ready, !o_ready && !o_valid)
    `ASSERT_IMPL(a_status_read, i_clk, i_rst_n, o_valid && o_status, o_count == 64'd0)
endmodule
